FILE: rtl/core/rtcep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcep_pkg
// Shared types, constants and helper functions for the clock-chip snapshot
// to epoch-seconds converter.
// ----------------------------------------------------------------------------
package rtcep_pkg;

  // Days from 1970-01-01 to 2000-01-01, minus one so that day 1 adds nothing.
  localparam logic [16:0] DaysTo2000M1 = 17'd10956;
  localparam int unsigned DaysW = 17;
  localparam int unsigned TodW  = 20;
  localparam int unsigned SecsW = 34;

  typedef struct packed {
    logic [7:0] raw_second;
    logic [7:0] raw_minute;
    logic [7:0] raw_hour;
    logic [7:0] raw_day;
    logic [7:0] raw_month;
    logic [7:0] raw_year;
  } rtcep_in_t;

  typedef struct packed {
    logic [SecsW-1:0] epoch_seconds;
    logic             bad_month;
  } rtcep_out_t;

  // Decoded snapshot, all fields binary.
  typedef struct packed {
    logic [7:0] second;
    logic [7:0] minute;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
  } rtcep_dec_t;

  // Day count and time of day, ready for the final multiply.
  typedef struct packed {
    logic [DaysW-1:0] days;
    logic [TodW-1:0]  tod;
    logic             bad_month;
  } rtcep_cnt_t;

  // BCD weighting keeps invalid nibbles as given, so the result stays below 166.
  function automatic logic [7:0] decode_byte(input logic bcd, input logic [7:0] v);
    logic [7:0] hi10;
    hi10 = {1'b0, v[7:4], 3'b000} + {3'b000, v[7:4], 1'b0};
    return bcd ? (hi10 + {4'b0000, v[3:0]}) : v;
  endfunction

  // Days before the first of a month; month is 1-based, and 0 or 13 to 15 give zero.
  function automatic logic [8:0] days_before_month(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/core/rtc_fields_to_epoch_seconds_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_fields_to_epoch_seconds_core
// Converts one snapshot of clock-chip time bytes into seconds since
// 1970-01-01 00:00:00. A new snapshot may be started in every clock cycle and
// its result appears, for one cycle, on out_data with out_valid high. The
// throughput of one snapshot per cycle is set by the three-stage pipeline:
// BCD decode, then day count and time-of-day, then the day-to-seconds
// multiply. The receiver cannot stall the block, so results are never held
// back. busy is high only while reset is applied and for the first cycle
// after it. A month outside 1 to 12 returns bad_month set and zero seconds.
// The year byte is taken as 2000 plus its decoded value, and Gregorian
// leap rules apply.
// ----------------------------------------------------------------------------
module rtc_fields_to_epoch_seconds_core (
  input  logic                   clk,
  input  logic                   rst_n,
  // Snapshot input: one transfer when start is high and busy is low.
  input  logic                   start,
  output logic                   busy,
  input  rtcep_pkg::rtcep_in_t   in_data,
  // Results: one cycle each, marked by out_valid.
  output logic                   out_valid,
  output rtcep_pkg::rtcep_out_t  out_data,
  // Configuration: bcd_mode register.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_data
);
  import rtcep_pkg::*;

  logic        busy_r;
  logic        bcd_mode_r;

  // Stage 1: decoded fields.
  logic        valid1_r;
  rtcep_dec_t  dec1_r;
  rtcep_dec_t  dec1_nxt;

  // Stage 2: day count and time of day.
  logic        valid2;
  rtcep_cnt_t  cnt2;

  // Stage 3: output register.
  logic        out_valid_r;
  rtcep_out_t  out_r;
  rtcep_out_t  out_nxt;
  logic [SecsW-1:0] secs;

  logic        in_fire;

  assign in_fire   = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  // The whole snapshot is decoded with the mode in force at the start transfer.
  always_comb begin
    dec1_nxt.second = decode_byte(bcd_mode_r, in_data.raw_second);
    dec1_nxt.minute = decode_byte(bcd_mode_r, in_data.raw_minute);
    dec1_nxt.hour   = decode_byte(bcd_mode_r, in_data.raw_hour);
    dec1_nxt.day    = decode_byte(bcd_mode_r, in_data.raw_day);
    dec1_nxt.month  = decode_byte(bcd_mode_r, in_data.raw_month);
    dec1_nxt.year   = decode_byte(bcd_mode_r, in_data.raw_year);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      bcd_mode_r <= 1'b1;
      valid1_r   <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      valid1_r <= in_fire;
      if (cfg_valid && cfg_ready) begin
        bcd_mode_r <= cfg_data;
      end
    end
    dec1_r <= dec1_nxt;
  end

  rtcep_day_count u_day_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (valid1_r),
    .in_dec    (dec1_r),
    .out_valid (valid2),
    .out_cnt   (cnt2)
  );

  // Days times 86400 plus the time of day; the sum always fits in 34 bits.
  always_comb begin
    secs = SecsW'(cnt2.days) * SecsW'(86400) + SecsW'(cnt2.tod);
    out_nxt.bad_month     = cnt2.bad_month;
    out_nxt.epoch_seconds = cnt2.bad_month ? '0 : secs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid2;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // Every start transfer yields its result strobe on out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result missing three cycles after start transfer");

  // A bad month always reports zero seconds.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bad_month) |-> (out_data.epoch_seconds == '0))
    else $error("bad month result carries nonzero seconds");

  // No result may appear in the cycle right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");
`endif

endmodule

FILE: rtl/core/rtcep_day_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcep_day_count
// Pipeline stage that turns a decoded snapshot into a day count since the
// epoch and a time-of-day second count.
// ----------------------------------------------------------------------------
module rtcep_day_count (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  rtcep_pkg::rtcep_dec_t  in_dec,
  output logic                   out_valid,
  output rtcep_pkg::rtcep_cnt_t  out_cnt
);
  import rtcep_pkg::*;

  logic             valid_r;
  rtcep_cnt_t       cnt_r;
  rtcep_cnt_t       cnt_nxt;
  logic [8:0]       yp3;
  logic [6:0]       leaps;
  logic             leap_year;
  logic [16:0]      year_days;
  logic [8:0]       dbm;
  logic             bad;

  always_comb begin
    // Leap years in 2000 .. 2000+y-1; 2100 and 2200 are not leap years.
    yp3   = {1'b0, in_dec.year} + 9'd3;
    leaps = yp3[8:2] - {6'd0, (in_dec.year >= 8'd101)} - {6'd0, (in_dec.year >= 8'd201)};
    leap_year = (in_dec.year[1:0] == 2'b00) && (in_dec.year != 8'd100) &&
                (in_dec.year != 8'd200);
    year_days = 17'(in_dec.year) * 17'd365;
    bad = (in_dec.month == 8'd0) || (in_dec.month > 8'd12);
    dbm = days_before_month(in_dec.month[3:0]);

    cnt_nxt.bad_month = bad;
    cnt_nxt.days = DaysTo2000M1 + year_days + 17'(leaps) + 17'(dbm) +
                   17'((in_dec.month > 8'd2) && leap_year) + 17'(in_dec.day);
    cnt_nxt.tod = TodW'(in_dec.hour) * TodW'(3600) + TodW'(in_dec.minute) * TodW'(60) +
                  TodW'(in_dec.second);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    cnt_r <= cnt_nxt;
  end

  assign out_valid = valid_r;
  assign out_cnt   = cnt_r;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the clock-chip snapshot to epoch-seconds converter.
// A queue of snapshots, filled phase by phase, feeds a bursty driver. Every
// snapshot that the block takes gets an expected epoch count from a local
// calendar model, and a monitor compares each result strobe against the
// oldest expectation. The BCD mode register is changed between phases, only
// once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_top;
  import rtcep_pkg::*;

  // Register values for bcd_mode.
  localparam logic MODE_BINARY = 1'b0;
  localparam logic MODE_BCD    = 1'b1;

  // Cycle limit for the run, far above what a correct run needs.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 105;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  rtcep_in_t  in_data = '0;
  logic       out_valid;
  rtcep_out_t out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  // Snapshots waiting for the driver, and results still owed by the block.
  rtcep_in_t   snap_q[$];
  rtcep_out_t  epoch_q[$];

  // Shadow copy of bcd_mode, updated at the edge of each register transfer.
  logic        bcd_shadow = MODE_BCD;

  int unsigned issued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned bad_month_cnt = 0;
  int unsigned mode_writes = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  // Driver pacing state.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  rtc_fields_to_epoch_seconds_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Calendar model
  // --------------------------------------------------------------------------

  // A BCD byte keeps nibbles above nine as given: high digit times ten plus
  // low digit, so the value can reach 165.
  function automatic longint unsigned byte_value(input logic [7:0] raw, input logic bcd);
    if (bcd) begin
      return 64'(raw[7:4]) * 10 + 64'(raw[3:0]);
    end
    return 64'(raw);
  endfunction

  // Leap years among years 1 through n.
  function automatic longint unsigned leaps_upto(input longint unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic bit is_leap(input longint unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Expected result for one snapshot under the given mode.
  function automatic rtcep_out_t epoch_of(input rtcep_in_t s, input logic bcd);
    rtcep_out_t        r;
    longint unsigned   mon;
    longint unsigned   k;
    longint unsigned   yr;
    longint unsigned   days;
    longint unsigned   total;
    r   = '0;
    mon = byte_value(s.raw_month, bcd);
    yr  = 2000 + byte_value(s.raw_year, bcd);
    if (mon < 1 || mon > 12) begin
      r.bad_month = 1'b1;
      return r;
    end
    days = 365 * (yr - 1970) + leaps_upto(yr - 1) - leaps_upto(1969);
    // Whole months before this one, February counted short here.
    for (k = 1; k < mon; k++) begin
      if (k == 2) begin
        days += 28;
      end else if (k == 4 || k == 6 || k == 9 || k == 11) begin
        days += 30;
      end else begin
        days += 31;
      end
    end
    if (mon > 2 && is_leap(yr)) begin
      days += 1;
    end
    // Day zero lands on the last day of the month before.
    days  = days + byte_value(s.raw_day, bcd) - 1;
    total = days * 24 + byte_value(s.raw_hour, bcd);
    total = total * 60 + byte_value(s.raw_minute, bcd);
    total = total * 60 + byte_value(s.raw_second, bcd);
    r.epoch_seconds = total[SecsW-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic [7:0] to_bcd(input int unsigned n);
    return {4'(n / 10), 4'(n % 10)};
  endfunction

  function automatic rtcep_in_t snap(input logic [7:0] s, input logic [7:0] mi,
                                     input logic [7:0] h, input logic [7:0] d,
                                     input logic [7:0] mo, input logic [7:0] y);
    rtcep_in_t r;
    r.raw_second = s;
    r.raw_minute = mi;
    r.raw_hour   = h;
    r.raw_day    = d;
    r.raw_month  = mo;
    r.raw_year   = y;
    return r;
  endfunction

  function automatic rtcep_in_t noise_bytes();
    return snap(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  // Mostly plausible calendar times in the current encoding, with a share of
  // arbitrary bytes and of months that are likely out of range.
  function automatic rtcep_in_t random_snapshot(input logic bcd);
    int unsigned pick;
    int unsigned s;
    int unsigned mi;
    int unsigned h;
    int unsigned d;
    int unsigned mo;
    int unsigned y;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      return noise_bytes();
    end
    s  = $urandom_range(0, 59);
    mi = $urandom_range(0, 59);
    h  = $urandom_range(0, 23);
    d  = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 31);
    mo = (pick == 2) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    y  = bcd ? $urandom_range(0, 99) : $urandom_range(0, 255);
    if (bcd) begin
      return snap(to_bcd(s), to_bcd(mi), to_bcd(h), to_bcd(d), to_bcd(mo), to_bcd(y));
    end
    return snap(8'(s), 8'(mi), 8'(h), 8'(d), 8'(mo), 8'(y));
  endfunction

  task automatic queue_snapshot(input rtcep_in_t s);
    snap_q.push_back(s);
    issued_cnt++;
  endtask

  // Idle means every queued snapshot was taken and every result has come back.
  task automatic wait_drained();
    while (accepted_cnt != issued_cnt || epoch_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // One transfer on the configuration channel. The shadow copy follows at the
  // edge where valid and ready are both seen high.
  task automatic write_mode(input logic mode);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do begin
      @(posedge clk);
    end while (cfg_ready !== 1'b1);
    bcd_shadow = mode;
    mode_writes++;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'($urandom_range(0, 1));
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts of snapshots separated by random gaps. A snapshot stays on
  // in_data with start high until the block takes it. While start is low the
  // data bus carries random bytes that the block must ignore.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (start && !busy) begin
        // The block took this snapshot at this edge, under the current mode.
        epoch_q.push_back(epoch_of(in_data, bcd_shadow));
        accepted_cnt++;
      end
      if (!start || !busy) begin
        if (burst_left == 0 && gap_left == 0) begin
          // Now and then a long run with no idle cycles at all.
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0) begin
          gap_left--;
          start   <= 1'b0;
          in_data <= noise_bytes();
        end else if (snap_q.size() != 0) begin
          in_data <= snap_q.pop_front();
          start   <= 1'b1;
          burst_left--;
        end else begin
          start   <= 1'b0;
          in_data <= noise_bytes();
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every result strobe is matched against the oldest expectation.
  // The block cannot be stalled, so the strobe is taken in the cycle it shows.
  // --------------------------------------------------------------------------
  rtcep_out_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (epoch_q.size() == 0) begin
        $error("result with nothing expected: epoch_seconds=%0d bad_month=%0b",
               out_data.epoch_seconds, out_data.bad_month);
        err_cnt++;
      end else begin
        want = epoch_q.pop_front();
        checked_cnt++;
        if (want.bad_month) begin
          bad_month_cnt++;
        end
        if (out_data.epoch_seconds !== want.epoch_seconds) begin
          $error("epoch_seconds: expected %0d, got %0d",
                 want.epoch_seconds, out_data.epoch_seconds);
          err_cnt++;
        end
        if (out_data.bad_month !== want.bad_month) begin
          $error("bad_month: expected %0b, got %0b", want.bad_month, out_data.bad_month);
          err_cnt++;
        end
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned ph;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // BCD mode out of reset: calendar corners and odd digit patterns.
    queue_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00)); // month zero
    queue_snapshot(snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF)); // decodes to 165
    queue_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00)); // start of 2000
    queue_snapshot(snap(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99)); // end of 2099
    queue_snapshot(snap(8'h56, 8'h34, 8'h12, 8'h29, 8'h02, 8'h00)); // leap day, 2000
    queue_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00)); // after a leap day
    queue_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01)); // common year
    queue_snapshot(snap(8'h07, 8'h08, 8'h09, 8'h10, 8'h13, 8'h24)); // month thirteen
    queue_snapshot(snap(8'h01, 8'h02, 8'h03, 8'h04, 8'h1A, 8'h50)); // month twenty
    queue_snapshot(snap(8'h30, 8'h15, 8'h06, 8'h05, 8'h0A, 8'h42)); // bad nibble, month ten
    queue_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h24)); // day zero
    queue_snapshot(snap(8'hFF, 8'hAF, 8'hF9, 8'h9F, 8'h0C, 8'hFF)); // nibbles past nine
    wait_drained();

    // Plain binary bytes, including values far past their normal range.
    write_mode(MODE_BINARY);
    queue_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    queue_snapshot(snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    queue_snapshot(snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd12, 8'hFF)); // largest count
    queue_snapshot(snap(8'd0, 8'd0, 8'd0, 8'd1, 8'd3, 8'd100));     // 2100 is common
    queue_snapshot(snap(8'd0, 8'd0, 8'd0, 8'd28, 8'd2, 8'd200));    // 2200; 2100 counted common
    queue_snapshot(snap(8'd59, 8'd59, 8'd23, 8'd29, 8'd2, 8'd0));
    queue_snapshot(snap(8'd1, 8'd1, 8'd1, 8'd1, 8'd13, 8'd10));     // month thirteen
    queue_snapshot(snap(8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0));       // last day of 1999
    queue_snapshot(snap(8'd0, 8'd0, 8'hFF, 8'd1, 8'd1, 8'd0));      // hour 255
    wait_drained();

    // Random phases, swapping the encoding each time.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      write_mode((ph % 2 == 0) ? MODE_BCD : MODE_BINARY);
      repeat (PHASE_ITEMS) begin
        queue_snapshot(random_snapshot(bcd_shadow));
      end
      wait_drained();
    end

    // Let any stray strobe show up before the verdict.
    repeat (8) @(posedge clk);

    $display("summary: %0d snapshots taken, %0d results checked, %0d with a bad month",
             accepted_cnt, checked_cnt, bad_month_cnt);
    $display("summary: %0d mode register writes, %0d mismatches", mode_writes, err_cnt);
    if (err_cnt == 0 && epoch_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: rtc_fields_to_epoch_seconds_core.f
rtl/core/rtcep_pkg.sv
rtl/core/rtcep_day_count.sv
rtl/core/rtc_fields_to_epoch_seconds_core.sv
tb/sv/tb_top.sv
